>>> src/kv_block_free_list_allocator_defines.svh
// Assertion helpers shared by the allocator RTL.
`ifndef KV_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define KV_BLOCK_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Concurrent check on the rising clock, held off while reset is applied.
`define KVFL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Concurrent check that an expression is never true.
`define KVFL_NEVER(name, expr, msg) \
  `KVFL_ASSERT(name, !(expr), msg)

`endif

>>> src/kvfl_pkg.sv
package kvfl_pkg;

  // Free list geometry.
  localparam int MaxBlocks = 64;
  localparam int AddrW     = $clog2(MaxBlocks);
  localparam int CntW      = $clog2(MaxBlocks + 1);

  // Field and register widths.
  localparam int IdW    = 48;
  localparam int PageW  = 16;
  localparam int BytesW = 33;
  localparam int CountW = 7;
  localparam int ProdW  = PageW + BytesW;
  localparam int DivW   = ProdW + 1;
  localparam int StepW  = $clog2(DivW);

  // Packed stream widths.
  localparam int InDataW  = 56;
  localparam int OutDataW = 64;

  typedef enum logic [1:0] {
    OpInit  = 2'd0,
    OpAlloc = 2'd1,
    OpFree  = 2'd2,
    OpNop   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StatOk       = 3'd0,
    StatNoFree   = 3'd1,
    StatNoInit   = 3'd2,
    StatOverflow = 3'd3,
    StatRange    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CfgPageIndex = 2'd0,
    CfgPageBytes = 2'd1,
    CfgBlockBytes = 2'd2
  } cfg_idx_e;

  // One result item as it sits in the output register.
  typedef struct packed {
    logic [IdW-1:0]  id;
    logic            has;
    logic            last;
    status_e         status;
    logic [CntW-1:0] free_cnt;
    logic            all_free;
    logic            none_free;
  } res_t;

  // Builds a result item; the flags follow from the list state after the step.
  function automatic res_t make_res(logic [IdW-1:0] id, logic has, logic last,
                                    status_e st, logic [CntW-1:0] cnt,
                                    logic init, logic [CntW-1:0] total);
    res_t r;
    r.id        = id;
    r.has       = has;
    r.last      = last;
    r.status    = st;
    r.free_cnt  = cnt;
    r.all_free  = init && (cnt == total);
    r.none_free = (cnt == '0);
    return r;
  endfunction

endpackage

>>> src/kv_block_free_list_allocator.sv
// Free, not-initialized, no-op and empty or zero-count allocate items: one result, in the cycle after acceptance.
// Allocate: each block id takes a store read, then an output register load that waits while the output stalls.
// Init: 16 shift-add steps,
// two 50-step restoring divisions through one shared subtractor, then one store write per id.
// Reset (asynchronous, active low): list empty, not initialized, registers at defaults;
// store contents are undefined until written.
`include "kv_block_free_list_allocator_defines.svh"

module kv_block_free_list_allocator
  import kvfl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // count[6:0], freed_id[54:7]
  input  logic [1:0]          s_axis_tuser_i,   // operation[1:0]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // alloc_id[47:0], status[50:48],
                                                // free_count[57:51], all_free[58],
                                                // none_free[59]
  output logic                m_axis_tuser_o,   // has_block
  output logic                m_axis_tlast_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_addr_i,
  input  logic [BytesW-1:0]   cfg_wdata_i
);

  typedef enum logic [3:0] {
    StIdle,
    StMul,
    StMulFin,
    StDivFirst,
    StDivEnd,
    StCheck,
    StFill,
    StAllocRd,
    StAllocEmit
  } state_e;

  // Configuration registers.
  logic [PageW-1:0]  page_index_q;
  logic [BytesW-1:0] page_bytes_q;
  logic [BytesW-1:0] block_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_index_q  <= '0;
      page_bytes_q  <= BytesW'(2097152);
      block_bytes_q <= BytesW'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgPageIndex:  page_index_q  <= cfg_wdata_i[PageW-1:0];
        CfgPageBytes:  page_bytes_q  <= cfg_wdata_i;
        CfgBlockBytes: block_bytes_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer and list state.
  state_e            state_q, state_d;
  logic [AddrW-1:0]  head_q, head_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   total_q, total_d;
  logic              init_q, init_d;
  logic [CntW-1:0]   remain_q, remain_d;

  // Arithmetic datapath.
  logic [BytesW-1:0] b_q, b_d;
  logic [PageW-1:0]  mplier_q, mplier_d;
  logic [ProdW-1:0]  mcand_q, mcand_d;
  logic [ProdW-1:0]  acc_q, acc_d;
  logic [DivW-1:0]   hi_q, hi_d;
  logic [DivW-1:0]   quo_q, quo_d;
  logic [BytesW-1:0] rem_q, rem_d;
  logic [DivW-1:0]   first_q, first_d;
  logic [StepW-1:0]  step_q, step_d;

  // Fill sweep.
  logic [CntW-1:0]   fill_idx_q, fill_idx_d;
  logic [CntW-1:0]   fill_n_q, fill_n_d;
  logic [IdW-1:0]    fill_id_q, fill_id_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  res_t              res_q, res_d;

  // Store ports.
  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [IdW-1:0]    mem_wdata;
  logic [IdW-1:0]    rd_q;
  logic [IdW-1:0]    store_mem [MaxBlocks];

  // Input fields.
  op_e               in_op;
  logic [CountW-1:0] in_cnt;
  logic [IdW-1:0]    in_id;
  logic              slot_free;
  logic              accept;

  // Shared division step and range check.
  logic [BytesW:0]   div_t;
  logic [BytesW:0]   div_sub;
  logic              div_ge;
  logic [BytesW-1:0] div_rem;
  logic [DivW-1:0]   div_quo;
  logic [DivW-1:0]   range_n;
  logic [CntW-1:0]   want;

  assign in_op  = op_e'(s_axis_tuser_i);
  assign in_cnt = s_axis_tdata_i[CountW-1:0];
  assign in_id  = s_axis_tdata_i[CountW +: IdW];

  assign slot_free       = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == StIdle) && slot_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // One restoring division step: bring down the next dividend bit, subtract if it fits.
  assign div_t   = {rem_q, quo_q[DivW-1]};
  assign div_sub = div_t - {1'b0, b_q};
  assign div_ge  = (div_t >= {1'b0, b_q});
  assign div_rem = div_ge ? div_sub[BytesW-1:0] : div_t[BytesW-1:0];
  assign div_quo = {quo_q[DivW-2:0], div_ge};

  // Number of whole blocks in the page; an empty or inverted range counts as zero.
  assign range_n = (quo_q > first_q) ? (quo_q - first_q) : '0;

  // Allocate request clamped to the list size.
  always_comb begin
    want = (in_cnt > CountW'(MaxBlocks)) ? CntW'(MaxBlocks) : CntW'(in_cnt);
    if (want > count_q) begin
      want = count_q;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    total_d     = total_q;
    init_d      = init_q;
    remain_d    = remain_q;
    b_d         = b_q;
    mplier_d    = mplier_q;
    mcand_d     = mcand_q;
    acc_d       = acc_q;
    hi_d        = hi_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    first_d     = first_q;
    step_d      = step_q;
    fill_idx_d  = fill_idx_q;
    fill_n_d    = fill_n_q;
    fill_id_d   = fill_id_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = fill_idx_q[AddrW-1:0];
    mem_wdata   = fill_id_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (in_op)
            OpInit: begin
              b_d      = (block_bytes_q == '0) ? BytesW'(1) : block_bytes_q;
              mplier_d = page_index_q;
              mcand_d  = ProdW'(page_bytes_q);
              acc_d    = '0;
              step_d   = '0;
              head_d   = '0;
              count_d  = '0;
              state_d  = StMul;
            end
            OpAlloc: begin
              if (!init_q) begin
                out_valid_d = 1'b1;
                res_d = make_res('0, 1'b0, 1'b1, StatNoInit, count_q, init_q, total_q);
              end else if (count_q == '0) begin
                out_valid_d = 1'b1;
                res_d = make_res('0, 1'b0, 1'b1, StatNoFree, count_q, init_q, total_q);
              end else if (in_cnt == '0) begin
                out_valid_d = 1'b1;
                res_d = make_res('0, 1'b0, 1'b1, StatOk, count_q, init_q, total_q);
              end else begin
                remain_d = want;
                state_d  = StAllocRd;
              end
            end
            OpFree: begin
              if (!init_q) begin
                out_valid_d = 1'b1;
                res_d = make_res('0, 1'b0, 1'b1, StatNoInit, count_q, init_q, total_q);
              end else if (count_q >= CntW'(MaxBlocks)) begin
                out_valid_d = 1'b1;
                res_d = make_res('0, 1'b0, 1'b1, StatOverflow, count_q, init_q, total_q);
              end else begin
                mem_we      = 1'b1;
                mem_waddr   = head_q + count_q[AddrW-1:0];
                mem_wdata   = in_id;
                count_d     = count_q + 1'b1;
                out_valid_d = 1'b1;
                res_d = make_res('0, 1'b0, 1'b1, StatOk, count_d, init_q, total_q);
              end
            end
            default: begin
              out_valid_d = 1'b1;
              res_d = make_res('0, 1'b0, 1'b1, StatOk, count_q, init_q, total_q);
            end
          endcase
        end
      end

      // Shift-add product of page index and page size, one multiplier bit a cycle.
      StMul: begin
        if (mplier_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        mplier_d = mplier_q >> 1;
        mcand_d  = mcand_q << 1;
        step_d   = step_q + 1'b1;
        if (step_q == StepW'(PageW - 1)) begin
          state_d = StMulFin;
        end
      end

      // Dividends: page start rounded up, and page end.
      StMulFin: begin
        hi_d    = DivW'(acc_q) + DivW'(page_bytes_q);
        quo_d   = DivW'(acc_q) + DivW'(b_q) - DivW'(1);
        rem_d   = '0;
        step_d  = '0;
        state_d = StDivFirst;
      end

      StDivFirst: begin
        quo_d  = div_quo;
        rem_d  = div_rem;
        step_d = step_q + 1'b1;
        if (step_q == StepW'(DivW - 1)) begin
          first_d = div_quo;
          quo_d   = hi_q;
          rem_d   = '0;
          step_d  = '0;
          state_d = StDivEnd;
        end
      end

      StDivEnd: begin
        quo_d  = div_quo;
        rem_d  = div_rem;
        step_d = step_q + 1'b1;
        if (step_q == StepW'(DivW - 1)) begin
          state_d = StCheck;
        end
      end

      // Reject a page that holds more blocks than the list can take.
      StCheck: begin
        if (range_n > DivW'(MaxBlocks)) begin
          if (slot_free) begin
            total_d     = '0;
            init_d      = 1'b0;
            out_valid_d = 1'b1;
            res_d = make_res('0, 1'b0, 1'b1, StatRange, count_q, 1'b0, '0);
            state_d     = StIdle;
          end
        end else begin
          fill_n_d   = range_n[CntW-1:0];
          fill_idx_d = '0;
          fill_id_d  = first_q[IdW-1:0];
          state_d    = StFill;
        end
      end

      // Write the ids of the page in ascending order, one entry a cycle.
      StFill: begin
        if (fill_idx_q == fill_n_q) begin
          if (slot_free) begin
            count_d     = fill_n_q;
            total_d     = fill_n_q;
            init_d      = 1'b1;
            out_valid_d = 1'b1;
            res_d = make_res('0, 1'b0, 1'b1, StatOk, fill_n_q, 1'b1, fill_n_q);
            state_d     = StIdle;
          end
        end else begin
          mem_we     = 1'b1;
          fill_idx_d = fill_idx_q + 1'b1;
          fill_id_d  = fill_id_q + 1'b1;
        end
      end

      // Wait for the registered store read at the head.
      StAllocRd: begin
        state_d = StAllocEmit;
      end

      StAllocEmit: begin
        if (slot_free) begin
          head_d      = head_q + 1'b1;
          count_d     = count_q - 1'b1;
          remain_d    = remain_q - 1'b1;
          out_valid_d = 1'b1;
          res_d = make_res(rd_q, 1'b1, (remain_q == CntW'(1)), StatOk, count_d,
                           init_q, total_q);
          state_d     = (remain_q == CntW'(1)) ? StIdle : StAllocRd;
        end
      end

      default: state_d = StIdle;
    endcase
  end

  // State, datapath and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      count_q     <= '0;
      total_q     <= '0;
      init_q      <= 1'b0;
      remain_q    <= '0;
      b_q         <= '0;
      mplier_q    <= '0;
      mcand_q     <= '0;
      acc_q       <= '0;
      hi_q        <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      first_q     <= '0;
      step_q      <= '0;
      fill_idx_q  <= '0;
      fill_n_q    <= '0;
      fill_id_q   <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      total_q     <= total_d;
      init_q      <= init_d;
      remain_q    <= remain_d;
      b_q         <= b_d;
      mplier_q    <= mplier_d;
      mcand_q     <= mcand_d;
      acc_q       <= acc_d;
      hi_q        <= hi_d;
      quo_q       <= quo_d;
      rem_q       <= rem_d;
      first_q     <= first_d;
      step_q      <= step_d;
      fill_idx_q  <= fill_idx_d;
      fill_n_q    <= fill_n_d;
      fill_id_q   <= fill_id_d;
      out_valid_q <= out_valid_d;
      res_q       <= res_d;
    end
  end

  // Free list store: one write port, registered read at the head.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= store_mem[head_q];
  end

  // Output ports.
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, res_q.none_free, res_q.all_free, res_q.free_cnt,
                            res_q.status, res_q.id};
  assign m_axis_tuser_o  = res_q.has;
  assign m_axis_tlast_o  = res_q.last;

  // Checks.
  `KVFL_NEVER(a_count_bound, count_q > CntW'(MaxBlocks), "free count above capacity")
  `KVFL_ASSERT(a_uninit_empty, !init_q |-> count_q == '0, "entries held while not initialized")
  `KVFL_ASSERT(a_emit_nonempty,
               state_q == StAllocEmit |-> count_q != '0 && remain_q != '0,
               "allocate step with nothing to hand out")
  `KVFL_ASSERT(a_free_grows,
               accept && in_op == OpFree && init_q && count_q < CntW'(MaxBlocks)
                 |=> count_q == $past(count_q) + 1'b1,
               "accepted free did not grow the list")

endmodule

>>> test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import kvfl_pkg::*;

  // One result item as the free list should report it.
  typedef struct {
    logic [IdW-1:0]  id;
    logic            has;
    logic            last;
    status_e         status;
    logic [CntW-1:0] free_cnt;
    logic            all_free;
    logic            none_free;
  } grant_t;

  // Clock, reset and block ports.
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;     // count[6:0], freed_id[54:7]
  logic [1:0]          s_axis_tuser_i = OpNop;  // operation[1:0]
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;          // alloc_id[47:0], status[50:48],
                                                // free_count[57:51], all_free[58],
                                                // none_free[59]
  logic                m_axis_tuser_o;          // has_block
  logic                m_axis_tlast_o;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_addr_i = CfgPageIndex;
  logic [BytesW-1:0]   cfg_wdata_i = '0;

  // Shadow copy of the page registers and of the free list.
  longint unsigned pg_index = 0;
  longint unsigned pg_bytes = 2097152;
  longint unsigned blk_bytes = 65536;
  logic [IdW-1:0]  fl_ids [MaxBlocks];
  int unsigned     fl_head = 0;
  int unsigned     fl_count = 0;
  int unsigned     fl_total = 0;
  bit              fl_ready = 1'b0;

  // Results still owed by the block, and ids handed out that may be freed again.
  grant_t          owed_results [$];
  logic [IdW-1:0]  lent_ids [$];

  int unsigned     mismatches = 0;
  bit              idle_off = 1'b0;
  int unsigned     hold_req = 0;

  kv_block_free_list_allocator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (idle_off) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IdW-1:0] random_id();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Queues one expected result; the flags follow the list state after the step.
  function automatic void owe_result(logic [IdW-1:0] id, logic has, logic last,
                                     status_e st);
    grant_t g;
    g.id        = id;
    g.has       = has;
    g.last      = last;
    g.status    = st;
    g.free_cnt  = CntW'(fl_count);
    g.all_free  = fl_ready && (fl_count == fl_total);
    g.none_free = (fl_count == 0);
    owed_results = {owed_results, g};
  endfunction

  // Applies one accepted item to the shadow free list and queues its results.
  function automatic void step_free_list(op_e op, logic [CountW-1:0] want,
                                         logic [IdW-1:0] id);
    longint unsigned bsz, first_blk, end_blk, nblk;
    int unsigned     take;
    logic [IdW-1:0]  id_out;
    status_e         st;
    st = StatOk;
    take = 0;
    case (op)
      OpInit: begin
        // A zero block size counts as one byte; an empty or inverted range holds no block.
        bsz       = (blk_bytes == 0) ? 1 : blk_bytes;
        first_blk = (pg_index * pg_bytes + bsz - 1) / bsz;
        end_blk   = ((pg_index + 1) * pg_bytes) / bsz;
        nblk      = (end_blk > first_blk) ? end_blk - first_blk : 0;
        fl_head   = 0;
        fl_count  = 0;
        lent_ids.delete();
        if (nblk > MaxBlocks) begin
          fl_total = 0;
          fl_ready = 1'b0;
          st       = StatRange;
        end else begin
          for (int i = 0; i < nblk; i++) fl_ids[i] = IdW'(first_blk + i);
          fl_count = int'(nblk);
          fl_total = int'(nblk);
          fl_ready = 1'b1;
        end
      end
      OpAlloc: begin
        // The list never holds more than 64 ids, so this also caps large counts.
        if (!fl_ready) st = StatNoInit;
        else if (fl_count == 0) st = StatNoFree;
        else take = (want < fl_count) ? want : fl_count;
      end
      OpFree: begin
        if (!fl_ready) st = StatNoInit;
        else if (fl_count >= MaxBlocks) st = StatOverflow;
        else begin
          fl_ids[(fl_head + fl_count) % MaxBlocks] = id;
          fl_count++;
        end
      end
      default: ;
    endcase
    for (int k = 0; k < take; k++) begin
      id_out  = fl_ids[fl_head];
      fl_head = (fl_head + 1) % MaxBlocks;
      fl_count--;
      lent_ids = {lent_ids, id_out};
      owe_result(id_out, 1'b1, k == take - 1, StatOk);
    end
    if (take == 0) owe_result('0, 1'b0, 1'b1, st);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("mismatch in %s: got %0h, expected %0h", what, got, want);
  endtask

  // Offers one item, waits for the handshake and then predicts its results.
  task automatic send_item(op_e op, logic [CountW-1:0] want, logic [IdW-1:0] id);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= InDataW'({id, want});
    s_axis_tuser_i  <= op;
    @(negedge clk_i);
    while (s_axis_tready_o !== 1'b1) @(negedge clk_i);
    @(posedge clk_i);
    step_free_list(op, want, id);
  endtask

  // Stops offering items until every owed result has come back.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Writes all three page registers; only called while the block is idle.
  task automatic write_regs(logic [PageW-1:0] idx, logic [BytesW-1:0] pbytes,
                            logic [BytesW-1:0] bbytes);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CfgPageIndex;
    cfg_wdata_i <= BytesW'(idx);
    @(posedge clk_i);
    cfg_addr_i  <= CfgPageBytes;
    cfg_wdata_i <= pbytes;
    @(posedge clk_i);
    cfg_addr_i  <= CfgBlockBytes;
    cfg_wdata_i <= bbytes;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pg_index  = idx;
    pg_bytes  = pbytes;
    blk_bytes = bbytes;
  endtask

  // Before any init, then an init with the register values left by reset.
  task automatic test_before_init();
    send_item(OpAlloc, 7'd1, '0);
    send_item(OpFree, 7'd5, 48'h1234);
    send_item(OpNop, 7'd127, '1);
    send_item(OpInit, 7'd0, '0);
    send_item(OpAlloc, 7'd3, '0);
    drain();
  endtask

  // Register extremes and the corner cases of init, allocate and free.
  task automatic test_geometry_extremes();
    // Exactly a full list: zero count, free into a full list, oversized count, empty list.
    write_regs(16'd0, 33'd64, 33'd1);
    send_item(OpInit, 7'd0, '0);
    send_item(OpAlloc, 7'd0, '0);
    send_item(OpFree, 7'd0, 48'hABC);
    send_item(OpAlloc, 7'd127, '0);
    send_item(OpAlloc, 7'd1, '0);
    send_item(OpFree, 7'd0, '1);
    send_item(OpFree, 7'd0, '0);
    send_item(OpAlloc, 7'd2, '0);
    drain();
    // Largest page and block: a single block at the top page index.
    write_regs(16'hFFFF, 33'h1_0000_0000, 33'h1_0000_0000);
    send_item(OpInit, 7'd0, '0);
    send_item(OpAlloc, 7'd1, '0);
    drain();
    // Range ends before it starts: initialized but empty.
    write_regs(16'hFFFF, 33'd1, 33'h1_0000_0000);
    send_item(OpInit, 7'd0, '0);
    send_item(OpAlloc, 7'd1, '0);
    drain();
    // Far more blocks than fit: the list becomes uninitialized.
    write_regs(16'd0, 33'h1_0000_0000, 33'd1);
    send_item(OpInit, 7'd0, '0);
    send_item(OpAlloc, 7'd5, '0);
    send_item(OpFree, 7'd0, 48'd9);
    drain();
    // Zero block size acts as one byte.
    write_regs(16'd2, 33'd20, 33'd0);
    send_item(OpInit, 7'd0, '0);
    send_item(OpAlloc, 7'd100, '0);
    drain();
    // One block over capacity.
    write_regs(16'd1, 33'd66560, 33'd1024);
    send_item(OpInit, 7'd0, '0);
    drain();
  endtask

  // Random page geometry per phase, then mostly well-formed alloc and free traffic.
  task automatic test_random_traffic(int unsigned phases, int unsigned items);
    longint unsigned bsz, base, psz;
    logic [PageW-1:0] idx;
    logic [IdW-1:0]   id;
    int unsigned      r, sel, k;
    for (int p = 0; p < phases; p++) begin
      drain();
      idle_off = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      if (r < 7) bsz = $urandom_range(1, 4096);
      else if (r < 9) bsz = $urandom_range(4097, 1 << 26);
      else bsz = $urandom_range(0, 1) ? 0 : 64'h1_0000_0000;
      base = (bsz == 0) ? 1 : bsz;
      k    = $urandom_range(0, 66);
      psz  = k * base + ({$urandom} % base);
      if (psz > 64'h1_0000_0000) psz = 64'h1_0000_0000;
      if (psz == 0) psz = 1;
      sel = $urandom_range(0, 7);
      if (sel == 0) idx = '0;
      else if (sel == 1) idx = '1;
      else idx = 16'($urandom);
      write_regs(idx, BytesW'(psz), BytesW'(bsz));
      send_item(OpInit, 7'd0, '0);
      for (int i = 0; i < items; i++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          sel = $urandom_range(0, 19);
          if (sel < 10) k = $urandom_range(1, 4);
          else if (sel < 15) k = $urandom_range(5, 20);
          else if (sel < 17) k = 0;
          else if (sel < 19) k = $urandom_range(21, 64);
          else k = $urandom_range(65, 127);
          send_item(OpAlloc, CountW'(k), random_id());
        end else if (r < 85) begin
          if (lent_ids.size() != 0 && $urandom_range(0, 9) < 7) begin
            sel = $urandom_range(0, lent_ids.size() - 1);
            id  = lent_ids[sel];
            lent_ids.delete(sel);
          end else begin
            id = random_id();
          end
          send_item(OpFree, CountW'($urandom), id);
        end else if (r < 92) begin
          send_item(OpNop, CountW'($urandom), random_id());
        end else begin
          send_item(OpInit, CountW'($urandom), random_id());
        end
      end
    end
    drain();
    idle_off = 1'b0;
  endtask

  // The result side holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    int unsigned sel;
    logic [IdW-1:0] id;
    idle_off = 1'b1;
    write_regs(16'd5, 33'd6400, 33'd100);
    send_item(OpInit, 7'd0, '0);
    hold_req = 300;
    for (int i = 0; i < 48; i++) begin
      if (i % 3 != 2 || lent_ids.size() == 0) begin
        send_item(OpAlloc, CountW'($urandom_range(1, 3)), '0);
      end else begin
        sel = $urandom_range(0, lent_ids.size() - 1);
        id  = lent_ids[sel];
        lent_ids.delete(sel);
        send_item(OpFree, 7'd0, id);
      end
    end
    drain();
    idle_off = 1'b0;
  endtask

  // Result side: random stalls, the long hold when asked, and the field checks.
  initial begin : result_sink
    int unsigned         stall_left;
    int unsigned         hold_left;
    grant_t              g;
    logic [OutDataW-1:0] d;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (m_axis_tvalid_o === 1'b1 && m_axis_tready_i === 1'b1) begin
        d = m_axis_tdata_o;
        if (owed_results.size() == 0) begin
          report_mismatch("unexpected result", d, '0);
        end else begin
          g = owed_results.pop_front();
          if (d[47:0] !== g.id) report_mismatch("alloc_id", d[47:0], g.id);
          if (m_axis_tuser_o !== g.has) report_mismatch("has_block", m_axis_tuser_o, g.has);
          if (m_axis_tlast_o !== g.last) report_mismatch("last", m_axis_tlast_o, g.last);
          if (d[50:48] !== g.status) report_mismatch("status", d[50:48], g.status);
          if (d[57:51] !== g.free_cnt) report_mismatch("free_count", d[57:51], g.free_cnt);
          if (d[58] !== g.all_free) report_mismatch("all_free", d[58], g.all_free);
          if (d[59] !== g.none_free) report_mismatch("none_free", d[59], g.none_free);
        end
      end
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        stall_left = pick_gap();
        if (stall_left == 0) begin
          m_axis_tready_i <= 1'b1;
        end else begin
          stall_left--;
          m_axis_tready_i <= 1'b0;
        end
      end
    end
  end

  // Test sequence.
  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_before_init();
    test_geometry_extremes();
    test_random_traffic(7, 24);
    test_backpressure();
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/kvfl_pkg.sv
src/kv_block_free_list_allocator.sv
test/tb_top.sv
